[src/dpb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the label color hash for the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

    localparam int EXCLUDE_SLOTS = 7;
    localparam int SLOT_W        = 9;
    localparam int CFG_DATA_W    = 63;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_NEAR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FAR   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_EXCL_SLOTS  = 3'd6;

    localparam logic [31:0] RST_INV_FOCAL_X = 32'd8021955;
    localparam logic [31:0] RST_INV_FOCAL_Y = 32'd7965422;
    localparam logic [15:0] RST_CENTER_X    = 16'd5122;
    localparam logic [15:0] RST_CENTER_Y    = 16'd3962;
    localparam logic [15:0] RST_DEPTH_NEAR  = 16'd100;
    localparam logic [15:0] RST_DEPTH_FAR   = 16'd8000;
    localparam logic [CFG_DATA_W-1:0] RST_EXCL_SLOTS = 63'd261888;

    localparam logic [7:0] BLUE_MUL    = 8'd37;
    localparam logic [7:0] BLUE_ADD    = 8'd53;
    localparam logic [7:0] GREEN_MUL   = 8'd17;
    localparam logic [7:0] GREEN_ADD   = 8'd101;
    localparam logic [7:0] RED_MUL     = 8'd29;
    localparam logic [7:0] RED_ADD     = 8'd197;
    localparam logic [7:0] GRAY_LEVEL  = 8'd180;
    localparam logic [7:0] LABEL_BG    = 8'd255;

    localparam int ROUND_SHIFT = 36;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic       point_valid;
        logic [15:0] z_mm;
        logic [7:0] class_id;
        rgb_t       color;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] mag_x;
        logic        neg_x;
        logic [15:0] mag_y;
        logic        neg_y;
    } gate_out_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    function automatic rgb_t label_color(input logic [7:0] label);
        rgb_t c;
        if (label == LABEL_BG)
        begin
            c.blue  = GRAY_LEVEL;
            c.green = GRAY_LEVEL;
            c.red   = GRAY_LEVEL;
        end
        else
        begin
            c.blue  = 8'(label * BLUE_MUL) + BLUE_ADD;
            c.green = 8'(label * GREEN_MUL) + GREEN_ADD;
            c.red   = 8'(label * RED_MUL) + RED_ADD;
        end
        return c;
    endfunction

endpackage

[src/dpb_gate.sv]
`timescale 1ns / 1ps
// First pipeline stage: depth and label gates, principal point offsets and label color.
// Depends on dpb_pkg.
module dpb_gate (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [11:0]                          column,
    input  logic [11:0]                          row,
    input  logic [15:0]                          depth_mm,
    input  logic [7:0]                           label,
    input  logic [15:0]                          center_x,
    input  logic [15:0]                          center_y,
    input  logic [15:0]                          depth_near,
    input  logic [15:0]                          depth_far,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       excl_slots,
    output dpb_pkg::gate_out_t                   gate_out
);
    import dpb_pkg::*;

    logic        excluded;
    logic        pass;
    logic [15:0] p4_x;
    logic [15:0] p4_y;
    logic        neg_x;
    logic        neg_y;
    gate_out_t   gate_next;
    gate_out_t   gate_reg;

    always_comb
    begin
        excluded = 1'b0;
        for (int k = 0; k < EXCLUDE_SLOTS; k++)
        begin
            if (excl_slots[k*SLOT_W + 8] && excl_slots[k*SLOT_W +: 8] == label)
            begin
                excluded = 1'b1;
            end
        end
    end

    always_comb
    begin
        pass  = (depth_mm != 16'd0) && (depth_mm > depth_near) && (depth_mm < depth_far)
                && !excluded;
        p4_x  = {column, 4'b0000};
        p4_y  = {row, 4'b0000};
        neg_x = p4_x < center_x;
        neg_y = p4_y < center_y;

        // A rejected pixel carries zeros so every later field comes out as zero.
        gate_next = '0;
        if (pass)
        begin
            gate_next.side.point_valid = 1'b1;
            gate_next.side.z_mm        = depth_mm;
            gate_next.side.class_id    = label;
            gate_next.side.color       = label_color(label);
            gate_next.neg_x            = neg_x;
            gate_next.neg_y            = neg_y;
            gate_next.mag_x            = neg_x ? (center_x - p4_x) : (p4_x - center_x);
            gate_next.mag_y            = neg_y ? (center_y - p4_y) : (p4_y - center_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gate_reg <= gate_next;
        end
    end

    assign gate_out = gate_reg;

endmodule

[src/dpb_project.sv]
`timescale 1ns / 1ps
// Three pipeline stages of one lateral coordinate: offset times depth, times the
// reciprocal focal length, then round to nearest and restore the sign. Depends on dpb_pkg.
module dpb_project (
    input  logic                clk,
    input  dpb_pkg::stage_en_t  en,
    input  logic [15:0]         mag,
    input  logic                neg,
    input  logic [15:0]         depth,
    input  logic [31:0]         inv_focal,
    output logic [31:0]         coord
);
    import dpb_pkg::*;

    logic [31:0] m_reg;
    logic        neg2_reg;
    logic [63:0] prod_reg;
    logic        neg3_reg;
    logic [31:0] coord_reg;
    logic [64:0] rounded;
    logic [31:0] mag_r;
    logic [31:0] coord_next;

    always_comb
    begin
        rounded    = {1'b0, prod_reg} + (65'd1 << (ROUND_SHIFT - 1));
        mag_r      = {3'b000, rounded[64:ROUND_SHIFT]};
        coord_next = neg3_reg ? (32'd0 - mag_r) : mag_r;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m_reg    <= 32'(mag) * 32'(depth);
            neg2_reg <= neg;
        end
        if (en.s3)
        begin
            prod_reg <= 64'(m_reg) * 64'(inv_focal);
            neg3_reg <= neg2_reg;
        end
        if (en.s4)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

[src/depth_pixel_backprojection.sv]
`timescale 1ns / 1ps
// Top level of the depth pixel back-projection block: configuration registers,
// pipeline control and the output register. Depends on dpb_pkg, dpb_gate, dpb_project.
//
//  Channel  | Handshake            | Beat contents
//  ---------+----------------------+------------------------------------------------
//  pixel in | in_valid / in_stall  | column, row, depth_mm, label
//  point out| out_valid / out_stall| point_valid, x_mm, y_mm, z_mm, class_id, colors
//  config   | cfg_we               | cfg_index, cfg_data
//
// One pixel per clock is accepted while in_stall is low; a result is offered from stage four.
// The four stages are gating, offset times depth, times reciprocal focal length,
// and rounding into the output register; the 32 by 32 multiplier sets the depth.
// Each stage moves when it is empty or the next one moves, so bubbles close up
// and in_stall rises only when all four stages hold beats and out_stall is high.
// Reset clears the stage valid bits and loads the default camera configuration.
module depth_pixel_backprojection (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [11:0]                          column,
    input  logic [11:0]                          row,
    input  logic [15:0]                          depth_mm,
    input  logic [7:0]                           label,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 point_valid,
    output logic signed [31:0]                   x_mm,
    output logic signed [31:0]                   y_mm,
    output logic [15:0]                          z_mm,
    output logic [7:0]                           class_id,
    output logic [7:0]                           blue,
    output logic [7:0]                           green,
    output logic [7:0]                           red,
    input  logic                                 cfg_we,
    input  logic [dpb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dpb_pkg::*;

    logic [31:0]           inv_focal_x_reg;
    logic [31:0]           inv_focal_y_reg;
    logic [15:0]           center_x_reg;
    logic [15:0]           center_y_reg;
    logic [15:0]           depth_near_reg;
    logic [15:0]           depth_far_reg;
    logic [CFG_DATA_W-1:0] excl_slots_reg;

    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      v4_reg;
    logic      en1;
    stage_en_t en;
    side_t     side2_reg;
    side_t     side3_reg;
    side_t     side4_reg;
    gate_out_t gate_out;
    logic [31:0] coord_x;
    logic [31:0] coord_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            depth_near_reg  <= RST_DEPTH_NEAR;
            depth_far_reg   <= RST_DEPTH_FAR;
            excl_slots_reg  <= RST_EXCL_SLOTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[31:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[31:0];
                REG_CENTER_X:    center_x_reg    <= cfg_data[15:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_data[15:0];
                REG_DEPTH_NEAR:  depth_near_reg  <= cfg_data[15:0];
                REG_DEPTH_FAR:   depth_far_reg   <= cfg_data[15:0];
                REG_EXCL_SLOTS:  excl_slots_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        en.s4 = !v4_reg || !out_stall;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en1   = !v1_reg || en.s2;
    end

    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            side2_reg <= gate_out.side;
        end
        if (en.s3)
        begin
            side3_reg <= side2_reg;
        end
        if (en.s4)
        begin
            side4_reg <= side3_reg;
        end
    end

    dpb_gate u_gate (
        .clk        (clk),
        .en         (en1),
        .column     (column),
        .row        (row),
        .depth_mm   (depth_mm),
        .label      (label),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .depth_near (depth_near_reg),
        .depth_far  (depth_far_reg),
        .excl_slots (excl_slots_reg),
        .gate_out   (gate_out)
    );

    dpb_project u_proj_x (
        .clk       (clk),
        .en        (en),
        .mag       (gate_out.mag_x),
        .neg       (gate_out.neg_x),
        .depth     (gate_out.side.z_mm),
        .inv_focal (inv_focal_x_reg),
        .coord     (coord_x)
    );

    dpb_project u_proj_y (
        .clk       (clk),
        .en        (en),
        .mag       (gate_out.mag_y),
        .neg       (gate_out.neg_y),
        .depth     (gate_out.side.z_mm),
        .inv_focal (inv_focal_y_reg),
        .coord     (coord_y)
    );

    assign out_valid   = v4_reg;
    assign point_valid = side4_reg.point_valid;
    assign x_mm        = coord_x;
    assign y_mm        = coord_y;
    assign z_mm        = side4_reg.z_mm;
    assign class_id    = side4_reg.class_id;
    assign blue        = side4_reg.color.blue;
    assign green       = side4_reg.color.green;
    assign red         = side4_reg.color.red;

endmodule

[src/dpb_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the depth pixel back-projection block, bound to its top level.
// Depends on depth_pixel_backprojection.
module dpb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               point_valid,
    input logic signed [31:0] x_mm,
    input logic signed [31:0] y_mm,
    input logic [15:0]        z_mm,
    input logic [7:0]         class_id,
    input logic [7:0]         blue,
    input logic [7:0]         green,
    input logic [7:0]         red
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while the beat was stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(x_mm) && $stable(y_mm) && $stable(class_id))
        else $error("stalled beat changed");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> x_mm == 0 && y_mm == 0 && z_mm == 16'd0
            && class_id == 8'd0 && blue == 8'd0 && green == 8'd0 && red == 8'd0)
        else $error("rejected pixel carries nonzero fields");

    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> z_mm != 16'd0)
        else $error("valid point with zero depth");

    a_background_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid && class_id == 8'd255 |->
            blue == 8'd180 && green == 8'd180 && red == 8'd180)
        else $error("background label is not gray");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_valid (point_valid),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .z_mm        (z_mm),
    .class_id    (class_id),
    .blue        (blue),
    .green       (green),
    .red         (red)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for depth_pixel_backprojection: a directed table of pixels and register
// writes, then random pixels under nine random camera settings, checked by a built-in predictor or fixed points.
// Depends on dpb_pkg and the RTL of the block.
module tb;
    import dpb_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int unsigned RUN_LIMIT_NS     = 2_000_000;
    localparam int          PIPE_DRAIN       = 8;
    localparam int          BLOCKS_PER_PHASE = 3;
    localparam int          BEATS_PER_BLOCK  = 128;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [15:0] depth_mm;
        logic [7:0]  label;
    } pixel_t;

    typedef struct packed {
        logic               point_valid;
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic [15:0]        z_mm;
        logic [7:0]         class_id;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } point_t;

    typedef struct packed {
        logic [31:0]           inv_fx;
        logic [31:0]           inv_fy;
        logic [15:0]           cx;
        logic [15:0]           cy;
        logic [15:0]           near_mm;
        logic [15:0]           far_mm;
        logic [CFG_DATA_W-1:0] excl;
    } camera_cfg_t;

    typedef enum logic { STEP_PIXEL, STEP_WRITE } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        pixel_t                 px;
        logic                   fixed;
        point_t                 want;
    } step_t;

    localparam point_t NO_POINT = '0;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [11:0]            column = '0;
    logic [11:0]            row = '0;
    logic [15:0]            depth_mm = '0;
    logic [7:0]             label = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   point_valid;
    logic signed [31:0]     x_mm;
    logic signed [31:0]     y_mm;
    logic [15:0]            z_mm;
    logic [7:0]             class_id;
    logic [7:0]             blue;
    logic [7:0]             green;
    logic [7:0]             red;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    camera_cfg_t camera;
    point_t      pending_points[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned fail_count = 0;

    depth_pixel_backprojection dut (.*);

    always #4 clk = ~clk;

    function automatic logic [31:0] camera_coord(input logic [11:0] pix, input logic [15:0] ctr,
                                                 input logic [15:0] depth, input logic [31:0] inv);
        logic [15:0] p4;
        logic        neg;
        logic [15:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        p4   = {pix, 4'b0000};
        neg  = p4 < ctr;
        mag  = neg ? ctr - p4 : p4 - ctr;
        prod = 64'(mag) * 64'(depth) * 64'(inv);
        r    = (prod + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (neg)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return 32'd0 - r[31:0];
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic logic label_blocked(input logic [7:0] lbl);
        logic [SLOT_W-1:0] slot;
        for (int k = 0; k < EXCLUDE_SLOTS; k++)
        begin
            slot = camera.excl[k*SLOT_W +: SLOT_W];
            if (slot[8] && slot[7:0] == lbl)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic point_t backproject_pixel(input pixel_t px);
        point_t p;
        p = '0;
        if (px.depth_mm == 0 || px.depth_mm <= camera.near_mm || px.depth_mm >= camera.far_mm
            || label_blocked(px.label))
            return p;
        p.point_valid = 1'b1;
        p.x_mm        = camera_coord(px.column, camera.cx, px.depth_mm, camera.inv_fx);
        p.y_mm        = camera_coord(px.row, camera.cy, px.depth_mm, camera.inv_fy);
        p.z_mm        = px.depth_mm;
        p.class_id    = px.label;
        if (px.label == LABEL_BG)
        begin
            p.blue  = GRAY_LEVEL;
            p.green = GRAY_LEVEL;
            p.red   = GRAY_LEVEL;
        end
        else
        begin
            p.blue  = 8'(16'(px.label) * BLUE_MUL + BLUE_ADD);
            p.green = 8'(16'(px.label) * GREEN_MUL + GREEN_ADD);
            p.red   = 8'(16'(px.label) * RED_MUL + RED_ADD);
        end
        return p;
    endfunction

    function automatic step_t px_step(input int c, input int r, input int d, input int l);
        return '{STEP_PIXEL, '0, '0, pixel_t'{12'(c), 12'(r), 16'(d), 8'(l)}, 1'b0, NO_POINT};
    endfunction

    function automatic step_t px_fixed(input int c, input int r, input int d, input int l,
                                       input point_t want);
        return '{STEP_PIXEL, '0, '0, pixel_t'{12'(c), 12'(r), 16'(d), 8'(l)}, 1'b1, want};
    endfunction

    function automatic step_t wr_step(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        return '{STEP_WRITE, idx, val, '0, 1'b0, NO_POINT};
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] pick_inv_focal();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return 32'((64'd1 << 32) / $urandom_range(150, 3000));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     sel;
        int     lo;
        int     hi;
        px.column = 12'($urandom);
        px.row    = 12'($urandom);
        lo        = int'(camera.near_mm) + 1;
        hi        = int'(camera.far_mm) - 1;
        sel       = $urandom_range(0, 99);
        if (sel < 70 && lo <= hi)
            px.depth_mm = 16'($urandom_range(lo, hi));
        else if (sel < 75)
            px.depth_mm = 16'd0;
        else if (sel < 80)
            px.depth_mm = camera.near_mm;
        else if (sel < 85)
            px.depth_mm = camera.far_mm;
        else
            px.depth_mm = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 20)
            px.label = camera.excl[$urandom_range(0, EXCLUDE_SLOTS - 1) * SLOT_W +: 8];
        else if (sel < 25)
            px.label = LABEL_BG;
        else if (sel < 28)
            px.label = 8'd0;
        else
            px.label = 8'($urandom);
        return px;
    endfunction

    task automatic drain_points();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_points();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_INV_FOCAL_X: camera.inv_fx  = val[31:0];
            REG_INV_FOCAL_Y: camera.inv_fy  = val[31:0];
            REG_CENTER_X:    camera.cx      = val[15:0];
            REG_CENTER_Y:    camera.cy      = val[15:0];
            REG_DEPTH_NEAR:  camera.near_mm = val[15:0];
            REG_DEPTH_FAR:   camera.far_mm  = val[15:0];
            REG_EXCL_SLOTS:  camera.excl    = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_t px, input logic fixed, input point_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        column   <= px.column;
        row      <= px.row;
        depth_mm <= px.depth_mm;
        label    <= px.label;
        pending_points.insert(pending_points.size(), fixed ? want : backproject_pixel(px));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic reprogram_camera();
        int          near_v;
        int          far_v;
        int          sel;
        logic [63:0] slots_v;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            near_v = 0;
            far_v  = 65535;
        end
        else if (sel == 1)
        begin
            near_v = $urandom_range(0, 65535);
            far_v  = $urandom_range(0, near_v);
        end
        else
        begin
            near_v = $urandom_range(0, 2000);
            far_v  = $urandom_range(near_v + 2, 65535);
        end
        slots_v = {$urandom, $urandom};
        write_reg(REG_INV_FOCAL_X, 63'(pick_inv_focal()));
        write_reg(REG_INV_FOCAL_Y, 63'(pick_inv_focal()));
        write_reg(REG_CENTER_X, 63'($urandom_range(0, 65535)));
        write_reg(REG_CENTER_Y, 63'($urandom_range(0, 65535)));
        write_reg(REG_DEPTH_NEAR, 63'(near_v));
        write_reg(REG_DEPTH_FAR, 63'(far_v));
        write_reg(REG_EXCL_SLOTS, slots_v[62:0]);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNMAPPED, {slots_v[61:0], 1'b1});
    endtask

    always @(posedge clk)
    begin : result_check
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result beat with no pixel outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("point_valid", want.point_valid, point_valid);
                check_field("x_mm", want.x_mm, x_mm);
                check_field("y_mm", want.y_mm, y_mm);
                check_field("z_mm", want.z_mm, z_mm);
                check_field("class_id", want.class_id, class_id);
                check_field("blue", want.blue, blue);
                check_field("green", want.green, green);
                check_field("red", want.red, red);
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin : stimulus
        step_t script[$];
        camera = '{RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y,
                   RST_DEPTH_NEAR, RST_DEPTH_FAR, RST_EXCL_SLOTS};
        send_idle_pct  = 12;
        recv_stall_pct = 71;
        script = '{
            px_fixed(0, 0, 0, 5, NO_POINT),
            px_fixed(10, 10, 100, 5, NO_POINT),
            px_fixed(10, 10, 8000, 5, NO_POINT),
            px_fixed(100, 50, 101, 0, NO_POINT),
            px_fixed(4095, 4095, 7999, 255, NO_POINT),
            px_step(4095, 4095, 7999, 1),
            px_step(0, 0, 101, 254),
            px_step(320, 247, 1000, 7),
            px_fixed(2048, 1024, 65535, 128, NO_POINT),
            wr_step(REG_EXCL_SLOTS, {9'h1C8, 36'd0, 9'h0FF, 9'h009}),
            px_step(300, 200, 500, 9),
            px_step(300, 200, 500, 255),
            px_fixed(300, 200, 500, 200, NO_POINT),
            wr_step(REG_INV_FOCAL_X, 63'd0),
            wr_step(REG_INV_FOCAL_Y, 63'd0),
            px_fixed(1234, 567, 500, 255, point_t'{1'b1, 32'sd0, 32'sd0, 16'd500, 8'd255,
                                                   8'd180, 8'd180, 8'd180}),
            wr_step(REG_INV_FOCAL_X, 63'hFFFF_FFFF),
            wr_step(REG_INV_FOCAL_Y, 63'hFFFF_FFFF),
            wr_step(REG_CENTER_X, 63'hFFFF),
            wr_step(REG_CENTER_Y, 63'd0),
            wr_step(REG_DEPTH_NEAR, 63'd0),
            wr_step(REG_DEPTH_FAR, 63'hFFFF),
            px_step(0, 4095, 65534, 17),
            px_step(4095, 0, 1, 42),
            px_fixed(5, 5, 0, 42, NO_POINT),
            px_fixed(5, 5, 65535, 42, NO_POINT),
            wr_step(REG_CENTER_X, 63'd0),
            wr_step(REG_CENTER_Y, 63'hFFFF),
            px_step(4095, 0, 65534, 100),
            wr_step(REG_DEPTH_NEAR, 63'd500),
            wr_step(REG_DEPTH_FAR, 63'd501),
            px_fixed(10, 10, 500, 3, NO_POINT),
            px_fixed(10, 10, 501, 3, NO_POINT),
            wr_step(REG_DEPTH_FAR, 63'd502),
            px_step(10, 10, 501, 3),
            wr_step(REG_DEPTH_NEAR, 63'hFFFF),
            wr_step(REG_DEPTH_FAR, 63'd0),
            px_fixed(10, 10, 32768, 3, NO_POINT),
            wr_step(REG_UNMAPPED, {CFG_DATA_W{1'b1}}),
            px_fixed(10, 10, 32768, 3, NO_POINT)
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (script[i])
        begin
            if (script[i].kind == STEP_WRITE)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_pixel(script[i].px, script[i].fixed, script[i].want);
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 12 : (phase == 1) ? 71 : 0;
            recv_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 12 : 0;
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++)
            begin
                reprogram_camera();
                repeat (BEATS_PER_BLOCK) send_pixel(random_pixel(), 1'b0, NO_POINT);
            end
        end
        drain_points();
        repeat (PIPE_DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("depth_pixel_backprojection test passed");
        else
            $display("depth_pixel_backprojection test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("depth_pixel_backprojection test failed");
        $finish;
    end

endmodule

[filelist.f]
src/dpb_pkg.sv
src/dpb_gate.sv
src/dpb_project.sv
src/depth_pixel_backprojection.sv
src/dpb_checker.sv
sim/tb.sv
